// ===== rtl/reliable_datagram_sequencer_assert.svh =====
// Assertion macros for the datagram sequencer.
// Included by the RTL files that carry concurrent checks; needs nothing else.
`ifndef RELIABLE_DATAGRAM_SEQUENCER_ASSERT_SVH
`define RELIABLE_DATAGRAM_SEQUENCER_ASSERT_SVH
`ifndef ASSERT_OFF
`define RDS_ASSERT(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define RDS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define RDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define RDS_ASSERT(lbl, clk, rstn, expr, msg)
`define RDS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define RDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/rds_pkg.sv =====
// Shared types, codes and sizes of the datagram sequencer.
// Used by rds_cfg_if, rds_result_buf and the top level; depends on nothing.
`default_nettype none
package rds_pkg;
	localparam int PENDING_SLOTS = 16;
	localparam int PEER_SLOTS = 8;
	localparam int MAX_RESULTS = 16;

	localparam int PIDX_W = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
	localparam int PCNT_W = $clog2(PENDING_SLOTS + 1);
	localparam int PEER_IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
	localparam int PEER_CNT_W = $clog2(PEER_SLOTS + 1);
	localparam int PEER_AW = PEER_IDX_W + 1;
	localparam int RES_W = $clog2(MAX_RESULTS + 1);

	localparam int SEQ_BYTES = 8;
	localparam int ACK_FRAME_LEN = SEQ_BYTES + 3;
	localparam logic [23:0] ACK_WORD = 24'h61636B;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd1;
	localparam logic [15:0] RETRY_INTERVAL_RST = 16'd1000;
	localparam logic [7:0] MAX_RETRIES_RST = 8'd10;

	localparam logic [1:0] FN_SEND = 2'd0;
	localparam logic [1:0] FN_RECV = 2'd1;
	localparam logic [1:0] FN_TICK = 2'd2;

	typedef enum logic [3:0] {
		K_ACCEPTED    = 4'd0,
		K_QUEUE_FULL  = 4'd1,
		K_TRANSMIT    = 4'd2,
		K_SEND_ACK    = 4'd3,
		K_DELIVER     = 4'd4,
		K_DUPLICATE   = 4'd5,
		K_GIVE_UP     = 4'd6,
		K_ACK_MATCHED = 4'd7,
		K_ACK_UNKNOWN = 4'd8,
		K_TOO_SHORT   = 4'd9,
		K_PEER_FULL   = 4'd10
	} kind_t;

	typedef struct packed {
		logic [47:0] peer;
		logic [63:0] seq;
		logic [7:0]  att;
		logic [31:0] enq;
		logic [15:0] buf_h;
	} pend_t;

	typedef struct packed {
		logic [47:0] addr;
		logic [63:0] seq;
	} peer_t;

	typedef struct packed {
		kind_t       kind;
		logic [47:0] peer;
		logic [63:0] seq;
		logic [15:0] handle;
	} res_t;

	typedef struct packed {
		logic emit;
		logic finish;
	} buf_ctrl_t;

	typedef struct packed {
		logic free;
		logic staged;
	} buf_stat_t;
endpackage
`default_nettype wire

// ===== rtl/rds_req_if.sv =====
// Request channel carrying one input item of the sequencer.
// Depends on nothing but its own fields.
`default_nettype none
interface rds_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [47:0] peer;
	logic [63:0] rx_seq;
	logic [15:0] rx_length;
	logic [23:0] rx_head;
	logic [15:0] handle;
	modport source(output valid, func, peer, rx_seq, rx_length, rx_head, handle, input ready);
	modport sink(input valid, func, peer, rx_seq, rx_length, rx_head, handle, output ready);
endinterface
`default_nettype wire

// ===== rtl/rds_rsp_if.sv =====
// Result channel carrying one result item of the sequencer.
// Depends on nothing but its own fields.
`default_nettype none
interface rds_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [47:0] out_peer;
	logic [63:0] out_seq;
	logic [15:0] out_handle;
	logic        last;
	modport source(output valid, kind, out_peer, out_seq, out_handle, last, input ready);
	modport sink(input valid, kind, out_peer, out_seq, out_handle, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/rds_cfg_if.sv =====
// Register write channel of the sequencer.
// Index width comes from rds_pkg.
`default_nettype none
interface rds_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rds_pkg::CFG_IDX_W-1:0]  index;
	logic [15:0]                    data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rds_ram.sv =====
// Generic one-write one-read synchronous RAM with registered read data.
// Self-contained; sized by its parameters.
`default_nettype none
module rds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic                                       re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/rds_result_buf.sv =====
// Result staging: holds the newest result until it is known whether it is the
// last one of its item, then passes it to the output register. Uses rds_pkg.
`default_nettype none
module rds_result_buf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rds_pkg::buf_ctrl_t  ctrl,
	input  wire rds_pkg::res_t       res,
	output rds_pkg::buf_stat_t       stat,
	rds_rsp_if.source                rsp
);
	logic          st_v_q;
	rds_pkg::res_t st_res_q;
	logic          ov_q;
	rds_pkg::res_t o_res_q;
	logic          o_last_q;
	logic          free;
	logic          load;

	assign free = !ov_q || rsp.ready;
	assign load = (ctrl.emit || ctrl.finish) && st_v_q && free;
	assign stat.free = free;
	assign stat.staged = st_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_v_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (ctrl.emit && free) begin
				st_v_q <= 1'b1;
			end else if (ctrl.finish && free) begin
				st_v_q <= 1'b0;
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && free) begin
			st_res_q <= res;
		end
		if (load) begin
			o_res_q <= st_res_q;
			o_last_q <= ctrl.finish;
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.kind = o_res_q.kind;
	assign rsp.out_peer = o_res_q.peer;
	assign rsp.out_seq = o_res_q.seq;
	assign rsp.out_handle = o_res_q.handle;
	assign rsp.last = o_last_q;
endmodule
`default_nettype wire

// ===== rtl/reliable_datagram_sequencer.sv =====
// Top level of the datagram sequencer: control sequencer, pending and peer
// memories, result staging. Uses rds_pkg, the channel interfaces, rds_ram and rds_result_buf.
// The block takes one item at a time and accepts the next one only after the
// last result of the previous item has left the staging register. A send
// reads each occupied peer slot and compares its address, passes each empty
// slot, and ends at the match or the table's end, all through the peer
// table's one read port. A data frame first emits its ack result, then makes
// the same walk. An ack frame reads and compares pending entries up to the
// match, then reads and writes each later entry one place down to close the
// gap. A tick reads and checks each pending entry in turn, and each give-up
// moves the later entries down the same way. A short frame goes straight to
// its one result. The walks are bounded by the one read port of the memory
// being walked; a slow result sink stretches them further.
`default_nettype none
`include "reliable_datagram_sequencer_assert.svh"
module reliable_datagram_sequencer (
	input  wire logic clk,
	input  wire logic arst_n,
	rds_req_if.sink   req,
	rds_rsp_if.source rsp,
	rds_cfg_if.sink   cfg
);
	// One-hot sequencer states.
	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_PL_CHK  = 13'b0000000000010,
		S_PL_CMP  = 13'b0000000000100,
		S_PL_DONE = 13'b0000000001000,
		S_ACK     = 13'b0000000010000,
		S_AK_CHK  = 13'b0000000100000,
		S_AK_CMP  = 13'b0000001000000,
		S_SH_RD   = 13'b0000010000000,
		S_SH_WR   = 13'b0000100000000,
		S_TK_CHK  = 13'b0001000000000,
		S_TK_EV   = 13'b0010000000000,
		S_ONE     = 13'b0100000000000,
		S_FIN     = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Latched item.
	logic [1:0]  func_q;
	logic [47:0] peer_q;
	logic [63:0] seq_q;
	logic [15:0] handle_q;

	// Peer lookup progress.
	logic [rds_pkg::PEER_CNT_W-1:0] idx_q;
	logic                           found_q;
	logic                           free_v_q;
	logic [rds_pkg::PEER_IDX_W-1:0] free_q;
	logic [rds_pkg::PEER_IDX_W-1:0] slot_q;
	logic [63:0]                    fseq_q;

	// Pending queue walk and compaction.
	logic [rds_pkg::PCNT_W-1:0] i_q;
	logic [rds_pkg::PCNT_W-1:0] sh_q;
	logic [rds_pkg::PCNT_W-1:0] pend_cnt_q;
	logic [rds_pkg::RES_W-1:0]  n_q;

	logic [31:0] tick_q;
	logic [15:0] ri_q;
	logic [7:0]  mr_q;
	rds_pkg::res_t r_q;

	logic tx_valid_q [rds_pkg::PEER_SLOTS];
	logic rx_valid_q [rds_pkg::PEER_SLOTS];

	// Memory ports.
	logic                           pm_we, pm_re;
	logic [rds_pkg::PIDX_W-1:0]     pm_waddr, pm_raddr;
	rds_pkg::pend_t                 pm_wdata, pm_rd;
	logic                           pp_we, pp_re;
	logic [rds_pkg::PEER_AW-1:0]    pp_waddr, pp_raddr;
	rds_pkg::peer_t                 pp_wdata, pp_rd;

	rds_pkg::buf_ctrl_t bctrl;
	rds_pkg::buf_stat_t bstat;
	rds_pkg::res_t      bres;

	logic                           is_rx;
	logic [rds_pkg::PEER_IDX_W-1:0] idx;
	logic                           pl_valid;
	logic                           pl_end;
	logic [rds_pkg::PEER_IDX_W-1:0] wslot;
	logic                           has_slot;
	logic                           q_full;
	logic [63:0]                    send_seq;
	logic                           send_ok;
	logic                           rx_dup;
	logic                           rx_ok;
	logic                           i_end;
	logic                           sh_end;
	logic [rds_pkg::PCNT_W-1:0]     sh_dec;
	logic                           ak_match;
	logic                           give;
	logic [31:0]                    elapsed;
	logic [23:0]                    wait_v;
	logic                           due;

	rds_ram #(
		.WIDTH($bits(rds_pkg::pend_t)),
		.DEPTH(rds_pkg::PENDING_SLOTS)
	) u_pend_mem (
		.clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
		.re(pm_re), .raddr(pm_raddr), .rdata(pm_rd)
	);

	// Transmit table in the lower half, receive table in the upper half.
	rds_ram #(
		.WIDTH($bits(rds_pkg::peer_t)),
		.DEPTH(2 ** rds_pkg::PEER_AW)
	) u_peer_mem (
		.clk(clk), .we(pp_we), .waddr(pp_waddr), .wdata(pp_wdata),
		.re(pp_re), .raddr(pp_raddr), .rdata(pp_rd)
	);

	rds_result_buf u_result_buf (
		.clk(clk), .arst_n(arst_n), .ctrl(bctrl), .res(bres), .stat(bstat), .rsp(rsp)
	);

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign is_rx = (func_q == rds_pkg::FN_RECV);
	assign idx = idx_q[rds_pkg::PEER_IDX_W-1:0];
	assign pl_end = (idx_q == rds_pkg::PEER_CNT_W'(rds_pkg::PEER_SLOTS));
	assign pl_valid = is_rx ? rx_valid_q[idx] : tx_valid_q[idx];
	assign wslot = found_q ? slot_q : free_q;
	assign has_slot = found_q || free_v_q;
	assign q_full = (pend_cnt_q == rds_pkg::PCNT_W'(rds_pkg::PENDING_SLOTS));
	assign send_seq = found_q ? fseq_q : 64'd0;
	assign send_ok = has_slot && !q_full;
	assign rx_dup = found_q && (seq_q <= fseq_q);
	assign rx_ok = !rx_dup && has_slot;
	assign i_end = (i_q == pend_cnt_q);
	assign sh_end = (sh_q == pend_cnt_q);
	assign sh_dec = sh_q - 1'b1;
	assign ak_match = (pm_rd.peer == peer_q) && (pm_rd.seq == seq_q);
	assign give = (pm_rd.att >= mr_q);
	assign elapsed = tick_q - pm_rd.enq;
	assign wait_v = 24'(pm_rd.att) * 24'(ri_q);
	assign due = (elapsed >= 32'(wait_v));

	always_comb begin
		pm_we = 1'b0;
		pm_waddr = pend_cnt_q[rds_pkg::PIDX_W-1:0];
		pm_wdata = pm_rd;
		pm_re = 1'b0;
		pm_raddr = i_q[rds_pkg::PIDX_W-1:0];
		pp_we = 1'b0;
		pp_waddr = {is_rx, wslot};
		pp_wdata.addr = peer_q;
		pp_wdata.seq = is_rx ? seq_q : send_seq + 64'd1;
		pp_re = 1'b0;
		pp_raddr = {is_rx, idx};
		bctrl.emit = 1'b0;
		bctrl.finish = 1'b0;
		bres = r_q;
		case (state_q)
			S_PL_CHK: begin
				pp_re = !pl_end && pl_valid;
			end
			S_PL_DONE: begin
				if (is_rx) begin
					pp_we = rx_ok;
				end else begin
					pp_we = send_ok;
					pm_we = send_ok;
					pm_wdata.peer = peer_q;
					pm_wdata.seq = send_seq;
					pm_wdata.att = 8'd0;
					pm_wdata.enq = tick_q;
					pm_wdata.buf_h = handle_q;
				end
			end
			S_ACK: begin
				bctrl.emit = bstat.free;
				bres.kind = rds_pkg::K_SEND_ACK;
				bres.peer = peer_q;
				bres.seq = seq_q;
				bres.handle = 16'd0;
			end
			S_AK_CHK: begin
				pm_re = !i_end;
			end
			S_SH_RD: begin
				pm_re = !sh_end;
				pm_raddr = sh_q[rds_pkg::PIDX_W-1:0];
			end
			S_SH_WR: begin
				pm_we = 1'b1;
				pm_waddr = sh_dec[rds_pkg::PIDX_W-1:0];
			end
			S_TK_CHK: begin
				pm_re = !i_end && (n_q != rds_pkg::RES_W'(rds_pkg::MAX_RESULTS));
			end
			S_TK_EV: begin
				bctrl.emit = (give || due) && bstat.free;
				bres.kind = give ? rds_pkg::K_GIVE_UP : rds_pkg::K_TRANSMIT;
				bres.peer = pm_rd.peer;
				bres.seq = pm_rd.seq;
				bres.handle = pm_rd.buf_h;
				pm_we = !give && due && bstat.free;
				pm_waddr = i_q[rds_pkg::PIDX_W-1:0];
				pm_wdata.att = pm_rd.att + 8'd1;
			end
			S_ONE: begin
				bctrl.emit = bstat.free;
			end
			S_FIN: begin
				bctrl.finish = bstat.staged && bstat.free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ri_q <= rds_pkg::RETRY_INTERVAL_RST;
			mr_q <= rds_pkg::MAX_RETRIES_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				rds_pkg::CFG_RETRY_INTERVAL: begin
					ri_q <= cfg.data;
				end
				rds_pkg::CFG_MAX_RETRIES: begin
					mr_q <= cfg.data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_cnt_q <= '0;
			tick_q <= 32'd0;
			i_q <= '0;
			sh_q <= '0;
			n_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			free_v_q <= 1'b0;
			for (int k = 0; k < rds_pkg::PEER_SLOTS; k++) begin
				tx_valid_q[k] <= 1'b0;
				rx_valid_q[k] <= 1'b0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						idx_q <= '0;
						found_q <= 1'b0;
						free_v_q <= 1'b0;
						i_q <= '0;
						n_q <= '0;
						case (req.func)
							rds_pkg::FN_SEND: begin
								state_q <= S_PL_CHK;
							end
							rds_pkg::FN_RECV: begin
								if (req.rx_length < 16'(rds_pkg::SEQ_BYTES)) begin
									state_q <= S_ONE;
								end else if (req.rx_length == 16'(rds_pkg::ACK_FRAME_LEN) &&
								             req.rx_head == rds_pkg::ACK_WORD) begin
									state_q <= S_AK_CHK;
								end else begin
									state_q <= S_ACK;
								end
							end
							rds_pkg::FN_TICK: begin
								tick_q <= tick_q + 32'd1;
								state_q <= S_TK_CHK;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_PL_CHK: begin
					if (pl_end) begin
						state_q <= S_PL_DONE;
					end else if (pl_valid) begin
						state_q <= S_PL_CMP;
					end else begin
						if (!free_v_q) begin
							free_v_q <= 1'b1;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				S_PL_CMP: begin
					if (pp_rd.addr == peer_q) begin
						found_q <= 1'b1;
						state_q <= S_PL_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_PL_CHK;
					end
				end
				S_PL_DONE: begin
					if (is_rx) begin
						if (rx_ok) begin
							rx_valid_q[wslot] <= 1'b1;
						end
					end else if (send_ok) begin
						if (!found_q) begin
							tx_valid_q[wslot] <= 1'b1;
						end
						pend_cnt_q <= pend_cnt_q + 1'b1;
					end
					state_q <= S_ONE;
				end
				S_ACK: begin
					if (bstat.free) begin
						state_q <= S_PL_CHK;
					end
				end
				S_AK_CHK: begin
					state_q <= i_end ? S_ONE : S_AK_CMP;
				end
				S_AK_CMP: begin
					if (ak_match) begin
						sh_q <= i_q + 1'b1;
						state_q <= S_SH_RD;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_AK_CHK;
					end
				end
				S_SH_RD: begin
					if (sh_end) begin
						pend_cnt_q <= pend_cnt_q - 1'b1;
						state_q <= (func_q == rds_pkg::FN_TICK) ? S_TK_CHK : S_ONE;
					end else begin
						state_q <= S_SH_WR;
					end
				end
				S_SH_WR: begin
					sh_q <= sh_q + 1'b1;
					state_q <= S_SH_RD;
				end
				S_TK_CHK: begin
					if (i_end || n_q == rds_pkg::RES_W'(rds_pkg::MAX_RESULTS)) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_TK_EV;
					end
				end
				S_TK_EV: begin
					if (give || due) begin
						if (bstat.free) begin
							n_q <= n_q + 1'b1;
							if (give) begin
								sh_q <= i_q + 1'b1;
								state_q <= S_SH_RD;
							end else begin
								i_q <= i_q + 1'b1;
								state_q <= S_TK_CHK;
							end
						end
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_TK_CHK;
					end
				end
				S_ONE: begin
					if (bstat.free) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!bstat.staged || bstat.free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload side: item fields, lookup results and the single result.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			func_q <= req.func;
			peer_q <= req.peer;
			seq_q <= req.rx_seq;
			handle_q <= req.handle;
			// A short frame is settled right away.
			r_q.kind <= rds_pkg::K_TOO_SHORT;
			r_q.peer <= req.peer;
			r_q.seq <= 64'd0;
			r_q.handle <= req.handle;
		end
		if (state_q == S_PL_CHK && !pl_end && !pl_valid && !free_v_q) begin
			free_q <= idx;
		end
		if (state_q == S_PL_CMP && pp_rd.addr == peer_q) begin
			slot_q <= idx;
			fseq_q <= pp_rd.seq;
		end
		if (state_q == S_PL_DONE) begin
			r_q.peer <= peer_q;
			r_q.handle <= handle_q;
			if (is_rx) begin
				r_q.seq <= seq_q;
				if (rx_dup) begin
					r_q.kind <= rds_pkg::K_DUPLICATE;
				end else if (!has_slot) begin
					r_q.kind <= rds_pkg::K_PEER_FULL;
				end else begin
					r_q.kind <= rds_pkg::K_DELIVER;
				end
			end else if (!has_slot) begin
				r_q.kind <= rds_pkg::K_PEER_FULL;
				r_q.seq <= 64'd0;
			end else if (q_full) begin
				r_q.kind <= rds_pkg::K_QUEUE_FULL;
				r_q.seq <= 64'd0;
			end else begin
				r_q.kind <= rds_pkg::K_ACCEPTED;
				r_q.seq <= send_seq;
			end
		end
		if (state_q == S_AK_CHK && i_end) begin
			r_q.kind <= rds_pkg::K_ACK_UNKNOWN;
			r_q.peer <= peer_q;
			r_q.seq <= seq_q;
			r_q.handle <= 16'd0;
		end
		if (state_q == S_AK_CMP && ak_match) begin
			r_q.kind <= rds_pkg::K_ACK_MATCHED;
			r_q.peer <= peer_q;
			r_q.seq <= seq_q;
			r_q.handle <= pm_rd.buf_h;
		end
	end

	// The queue never holds more entries than it has slots.
	`RDS_ASSERT(a_cnt_bound, clk, arst_n,
		pend_cnt_q <= rds_pkg::PCNT_W'(rds_pkg::PENDING_SLOTS), "pending count overflow")
	// A new item is only taken once the previous item's results are all out of staging.
	`RDS_ASSERT_IMPL(a_idle_clean, clk, arst_n, req.ready, !bstat.staged,
		"staged result left behind at idle")
	// A tick never produces more than the result cap.
	`RDS_ASSERT(a_res_cap, clk, arst_n,
		n_q <= rds_pkg::RES_W'(rds_pkg::MAX_RESULTS), "tick result cap exceeded")
	// Reads and writes of the pending memory never collide on one entry.
	`RDS_ASSERT(a_pm_collide, clk, arst_n,
		!(pm_we && pm_re && pm_waddr == pm_raddr), "pending memory read during write")
endmodule
`default_nettype wire
